FILE: sv/cnsp_pkg.sv
`default_nettype none

package cnsp_pkg;

    typedef enum logic [2:0] {
        KIND_NAME  = 3'd0,
        KIND_ENTRY = 3'd1,
        KIND_DATA  = 3'd2,
        KIND_END   = 3'd3,
        KIND_BAD   = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] value;
        logic        last;
    } result_t;

    // results produced by one accepted item, r0 first
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } push_t;

    typedef struct packed {
        logic emit_names;
        logic emit_data;
        logic expand_newline;
    } cfg_t;

    localparam int ADDR_W = 4;

    localparam logic [1:0] REG_EMIT_NAMES  = 2'd0;
    localparam logic [1:0] REG_EMIT_DATA   = 2'd1;
    localparam logic [1:0] REG_EXPAND_NL   = 2'd2;

    localparam logic [31:0] MAGIC_LEN   = 32'd6;
    localparam logic [31:0] FSIZE_AT    = 32'd54;
    localparam logic [31:0] NSIZE_AT    = 32'd94;
    localparam logic [31:0] HEX_DIGITS  = 32'd8;
    localparam logic [31:0] HDR_LEN     = 32'd110;
    localparam logic [31:0] TRAILER_LEN = 32'd11;

    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;

    function automatic logic [7:0] magic_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = "0";
            3'd1:    c = "7";
            3'd2:    c = "0";
            3'd3:    c = "7";
            3'd4:    c = "0";
            3'd5:    c = "1";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] trailer_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = "T";
            4'd1:    c = "R";
            4'd2:    c = "A";
            4'd3:    c = "I";
            4'd4:    c = "L";
            4'd5:    c = "E";
            4'd6:    c = "R";
            4'd7:    c = "!";
            4'd8:    c = "!";
            4'd9:    c = "!";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: sv/cnsp_parser.sv
`default_nettype none

module cnsp_parser
    import cnsp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_accept,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_start,
    input  wire cfg_t       cfg,
    output push_t           push
);

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_NAME    = 3'd1,
        PH_NAMEPAD = 3'd2,
        PH_DATA    = 3'd3,
        PH_DATAPAD = 3'd4,
        PH_ERROR   = 3'd5,
        PH_END     = 3'd6
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] fsize_reg, fsize_next;
    logic [31:0] nsize_reg, nsize_next;
    logic        tmatch_reg, tmatch_next;

    phase_t      ph;
    logic [31:0] pos;
    logic [31:0] pos_inc;
    logic [31:0] fsize;
    logic [31:0] nsize;
    logic        tmatch;
    logic [31:0] digit;
    logic        do_finish;
    result_t     r0, r1;
    logic [1:0]  n;
    result_t     fin;

    function automatic phase_t after_data(input logic [31:0] fs);
        return ((2'd0 - fs[1:0]) != 2'd0) ? PH_DATAPAD : PH_HEADER;
    endfunction

    function automatic phase_t after_namepad(input logic [31:0] fs);
        return (fs != 32'd0) ? PH_DATA : after_data(fs);
    endfunction

    function automatic phase_t after_name(input logic [31:0] ns, input logic [31:0] fs);
        return ((2'd2 - ns[1:0]) != 2'd0) ? PH_NAMEPAD : after_namepad(fs);
    endfunction

    always_comb
    begin
        ph      = in_start ? PH_HEADER : phase_reg;
        pos     = in_start ? 32'd0 : pos_reg;
        fsize   = in_start ? 32'd0 : fsize_reg;
        nsize   = in_start ? 32'd0 : nsize_reg;
        tmatch  = in_start ? 1'b1 : tmatch_reg;
        pos_inc = pos + 32'd1;
        digit   = (in_byte >= CHAR_UPPER_A) ? ({24'd0, in_byte} - 32'd55)
                                            : ({24'd0, in_byte} - 32'd48);

        phase_next  = ph;
        pos_next    = pos;
        fsize_next  = fsize;
        nsize_next  = nsize;
        tmatch_next = tmatch;
        do_finish   = 1'b0;
        n           = 2'd0;
        r0          = '{kind: KIND_NAME, value: 32'd0, last: 1'b0};
        r1          = '{kind: KIND_NAME, value: 32'd0, last: 1'b0};

        case (ph)
            PH_HEADER:
            begin
                if (pos < MAGIC_LEN && in_byte != magic_char(pos[2:0]))
                begin
                    r0         = '{kind: KIND_BAD, value: 32'd0, last: 1'b0};
                    n          = 2'd1;
                    phase_next = PH_ERROR;
                end
                else
                begin
                    if (pos >= FSIZE_AT && pos < FSIZE_AT + HEX_DIGITS)
                        fsize_next = ((pos == FSIZE_AT) ? 32'd0 : {fsize[27:0], 4'd0}) + digit;
                    if (pos >= NSIZE_AT && pos < NSIZE_AT + HEX_DIGITS)
                        nsize_next = ((pos == NSIZE_AT) ? 32'd0 : {nsize[27:0], 4'd0}) + digit;
                    pos_next = pos_inc;
                    if (pos_inc == HDR_LEN)
                    begin
                        pos_next    = 32'd0;
                        tmatch_next = 1'b1;
                        if (nsize_next == 32'd0)
                            do_finish = 1'b1;
                        else
                            phase_next = PH_NAME;
                    end
                end
            end
            PH_NAME:
            begin
                if (cfg.emit_names)
                begin
                    r0 = '{kind: KIND_NAME, value: {24'd0, in_byte}, last: 1'b0};
                    n  = 2'd1;
                end
                if (pos < TRAILER_LEN && in_byte != trailer_char(pos[3:0]))
                    tmatch_next = 1'b0;
                pos_next = pos_inc;
                if (pos_inc == nsize)
                    do_finish = 1'b1;
            end
            PH_NAMEPAD:
            begin
                pos_next = pos_inc;
                if (pos_inc == {30'd0, 2'd2 - nsize[1:0]})
                begin
                    pos_next   = 32'd0;
                    phase_next = after_namepad(fsize);
                end
            end
            PH_DATA:
            begin
                if (cfg.emit_data)
                begin
                    if (cfg.expand_newline && in_byte == CHAR_LF)
                    begin
                        r0 = '{kind: KIND_DATA, value: {24'd0, CHAR_CR}, last: 1'b0};
                        r1 = '{kind: KIND_DATA, value: {24'd0, in_byte}, last: 1'b0};
                        n  = 2'd2;
                    end
                    else
                    begin
                        r0 = '{kind: KIND_DATA, value: {24'd0, in_byte}, last: 1'b0};
                        n  = 2'd1;
                    end
                end
                pos_next = pos_inc;
                if (pos_inc == fsize)
                begin
                    pos_next   = 32'd0;
                    phase_next = after_data(fsize);
                end
            end
            PH_DATAPAD:
            begin
                pos_next = pos_inc;
                if (pos_inc == {30'd0, 2'd0 - fsize[1:0]})
                begin
                    pos_next   = 32'd0;
                    phase_next = PH_HEADER;
                end
            end
            default:
            begin
            end
        endcase

        // entry done, or archive end on the trailer entry
        fin = '{kind: KIND_ENTRY, value: fsize_next, last: 1'b0};
        if (do_finish)
        begin
            if (tmatch_next && nsize_next >= TRAILER_LEN)
            begin
                fin        = '{kind: KIND_END, value: 32'd0, last: 1'b0};
                phase_next = PH_END;
            end
            else
            begin
                pos_next   = 32'd0;
                phase_next = after_name(nsize_next, fsize_next);
            end
            if (n == 2'd0)
                r0 = fin;
            else
                r1 = fin;
            n = n + 2'd1;
        end

        if (n == 2'd1)
            r0.last = 1'b1;
        if (n == 2'd2)
            r1.last = 1'b1;

        push.count = n;
        push.r0    = r0;
        push.r1    = r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            pos_reg    <= 32'd0;
            fsize_reg  <= 32'd0;
            nsize_reg  <= 32'd0;
            tmatch_reg <= 1'b1;
        end
        else if (in_accept)
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            fsize_reg  <= fsize_next;
            nsize_reg  <= nsize_next;
            tmatch_reg <= tmatch_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/cnsp_out_q.sv
`default_nettype none

module cnsp_out_q
    import cnsp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push_en,
    input  wire push_t push,
    output logic       room,
    output logic       head_valid,
    input  wire logic  head_ready,
    output result_t    head
);

    localparam int DEPTH = 3;

    result_t    slot_reg [DEPTH];
    result_t    slot_next [DEPTH];
    logic [1:0] count_reg, count_next;
    logic       pop;
    logic [1:0] base;

    always_comb
    begin
        pop  = (count_reg != 2'd0) && head_ready;
        base = count_reg - {1'b0, pop};
        for (int i = 0; i < DEPTH; i++)
        begin
            if (pop && i < DEPTH - 1)
                slot_next[i] = slot_reg[i + 1];
            else
                slot_next[i] = slot_reg[i];
            if (push_en && push.count != 2'd0 && 2'(i) == base)
                slot_next[i] = push.r0;
            if (push_en && push.count == 2'd2 && 2'(i) == base + 2'd1)
                slot_next[i] = push.r1;
        end
        count_next = push_en ? base + push.count : base;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
            slot_reg[i] <= slot_next[i];
    end

    // room for the two results one item may bring
    assign room       = (count_reg <= 2'd1);
    assign head_valid = (count_reg != 2'd0);
    assign head       = slot_reg[0];

endmodule

`default_nettype wire

FILE: sv/cpio_newc_stream_parser.sv
// cpio newc archive parser, one archive byte per input item.
//
// Input channel s_*: tdata carries the archive byte, tuser[0] set restarts
// parsing with this byte as header byte zero (registers are kept).
// Output channel m_*: tuser is the result kind (name byte, entry done, data
// byte, archive end, bad magic), tdata the byte value or file size, tlast
// marks the final result of one input byte.
// Registers on the APB port: 0x0 emit_names, 0x4 emit_data,
// 0x8 expand_newline; write only while the stream is idle.
//
// A result enters the result queue when its byte is taken and is shown on m_tvalid from its head.
// Throughput: one byte per cycle while m_tready is high and each byte gives at most
// one result; the result queue holds three results and s_tready drops while two or
// more wait, so a byte giving two results (last name byte, expanded LF) holds off the
// next byte. The parse state update is a 32-bit position add and compare.
// Reset: registers return to defaults, the parser waits for header byte zero,
// the queue is empty. When m_tready is low, results stay queued and input
// is held off once the queue cannot take two more.
`default_nettype none

module cpio_newc_stream_parser
    import cnsp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // slave channel
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,   // [7:0] archive_byte
    input  wire logic              s_tuser,   // [0] start_of_archive
    // master channel
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [31:0]            m_tdata,   // [31:0] value
    output logic [2:0]             m_tuser,   // [2:0] kind
    output logic                   m_tlast,
    // config
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    cfg_t    cfg_reg;
    logic    in_accept;
    logic    cfg_write;
    push_t   push;
    result_t head;
    logic    room;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.emit_names     <= 1'b1;
            cfg_reg.emit_data      <= 1'b1;
            cfg_reg.expand_newline <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_EMIT_NAMES: cfg_reg.emit_names     <= pwdata[0];
                REG_EMIT_DATA:  cfg_reg.emit_data      <= pwdata[0];
                REG_EXPAND_NL:  cfg_reg.expand_newline <= pwdata[0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_EMIT_NAMES: prdata = {31'd0, cfg_reg.emit_names};
            REG_EMIT_DATA:  prdata = {31'd0, cfg_reg.emit_data};
            REG_EXPAND_NL:  prdata = {31'd0, cfg_reg.expand_newline};
            default:        prdata = 32'd0;
        endcase
    end

    assign s_tready  = room;
    assign in_accept = s_tvalid && s_tready;

    cnsp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .in_start  (s_tuser),
        .cfg       (cfg_reg),
        .push      (push)
    );

    cnsp_out_q u_out_q (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_en    (in_accept),
        .push       (push),
        .room       (room),
        .head_valid (m_tvalid),
        .head_ready (m_tready),
        .head       (head)
    );

    assign m_tdata = head.value;
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule

`default_nettype wire

FILE: sv/cnsp_checker.sv
`default_nettype none

module cnsp_checker
    import cnsp_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              s_tvalid,
    input wire logic              s_tready,
    input wire logic [7:0]        s_tdata,
    input wire logic              s_tuser,
    input wire logic              m_tvalid,
    input wire logic              m_tready,
    input wire logic [31:0]       m_tdata,
    input wire logic [2:0]        m_tuser,
    input wire logic              m_tlast,
    input wire logic              psel,
    input wire logic              penable,
    input wire logic              pwrite,
    input wire logic [ADDR_W-1:0] paddr,
    input wire logic [31:0]       pwdata,
    input wire logic [31:0]       prdata,
    input wire logic              pready
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser <= KIND_BAD)
        else $error("undefined result kind");

    // byte results carry a byte
    a_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_NAME || m_tuser == KIND_DATA) |-> m_tdata[31:8] == 24'd0)
        else $error("byte result wider than a byte");

    // end and bad magic are the last result for their byte and carry zero
    a_final: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_END || m_tuser == KIND_BAD) |-> m_tlast && m_tdata == 32'd0)
        else $error("terminal result malformed");

endmodule

bind cpio_newc_stream_parser cnsp_checker u_cnsp_checker (.*);

`default_nettype wire
